/* hw/rtl/sha1sh_pkg.sv */
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared types and constants of the streaming SHA-1 hash unit: chaining value
// start words, round constants, controller commands and datapath status.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

  localparam int WORD_BYTES      = 4;
  localparam int BLOCK_BYTES     = 64;
  localparam int BLOCK_WORDS     = 16;
  localparam int LEN_POS         = 56;
  localparam int ROUNDS          = 80;
  localparam int ROUNDS_PER_STEP = 20;
  localparam int DIGEST_WORDS    = 5;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // entry 0 is the first chaining word
  localparam logic [4:0][31:0] INIT_CV = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [3:0][31:0] ROUND_K = {
    32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
  };

  // round function selection, one per group of twenty rounds
  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } phase_t;

  typedef struct packed {
    logic   ins_new;   // pack the accepted word into the block store
    logic   ins_pend;  // pack the held remainder of a straddling word
    logic   pad;       // write end marker, zero fill and length if it fits
    logic   len_only;  // write a block of zeros and the length
    logic   start;     // load the working words from the chaining value
    logic   round;     // run one compression round
    phase_t phase;
    logic   sched;     // expand the schedule instead of reading it
    logic   fold;      // add the working words into the chaining value
    logic   reinit;    // restart chaining value and counters
    logic   emit;      // hand the digest to the output stage
  } cmd_t;

  typedef struct packed {
    logic full;       // the current insertion completes the block
    logic pend_left;  // bytes remain after the current insertion
    logic pad_fits;   // the length still fits in the current block
  } status_t;

endpackage

/* hw/rtl/sha1_stream_hash_unit.sv */
// ----------------------------------------------------------------------------
// sha1_stream_hash_unit
// Streaming SHA-1 hash: big-endian message words in, five digest words out.
// A word that does not complete a block is packed into the block store; one
// that completes a block also starts 80 rounds, one per cycle, and a fold,
// then packs any bytes that spill into the next block. Closing a message
// adds a pad write, 80 rounds and a fold, and when the length does not fit
// a length block, 80 more rounds and a second fold; the closing fold waits
// while an earlier digest is still leaving. The digest then leaves as five
// beats while the next message is taken. Reset restores the start chaining
// value and clears the counts.
// ----------------------------------------------------------------------------
module sha1_stream_hash_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // [31:0] data_word, [34:32] valid_bytes, [39:35] zero
  input  logic         s_tlast,   // end_of_message
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // [31:0] digest_word
  output logic [2:0]   m_tuser,   // [2:0] word_index
  output logic         m_tlast    // last_word
);

  sha1sh_pkg::cmd_t    cmd;
  sha1sh_pkg::status_t st;
  logic [4:0][31:0]    digest;
  logic                out_busy;

  sha1sh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .st       (st),
    .out_busy (out_busy),
    .cmd      (cmd)
  );

  sha1sh_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .data_word   (s_tdata[31:0]),
    .valid_bytes (s_tdata[34:32]),
    .cmd         (cmd),
    .st          (st),
    .digest      (digest)
  );

  sha1sh_out u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (cmd.emit),
    .digest (digest),
    .tvalid (m_tvalid),
    .tready (m_tready),
    .tdata  (m_tdata),
    .tuser  (m_tuser),
    .tlast  (m_tlast),
    .busy   (out_busy)
  );

endmodule

/* hw/rtl/sha1sh_dpath.sv */
// ----------------------------------------------------------------------------
// sha1sh_dpath
// Datapath: byte packing into the block store, padding and length, the
// schedule shift line, one SHA-1 round per cycle and the chaining value.
// ----------------------------------------------------------------------------
module sha1sh_dpath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [31:0]           data_word,
  input  logic [2:0]            valid_bytes,
  input  sha1sh_pkg::cmd_t      cmd,
  output sha1sh_pkg::status_t   st,
  output logic [4:0][31:0]      digest
);

  logic [31:0]       blk [16];
  logic [5:0]        fill;
  logic [60:0]       msg_len;
  logic [31:0]       pend_word;
  logic [2:0]        pend_cnt;
  logic [4:0][31:0]  cv;
  logic [4:0][31:0]  wk;

  logic [2:0]        n_in;
  logic [31:0]       src_word;
  logic [2:0]        src_cnt;
  logic [6:0]        fill_sum;
  logic [6:0]        room;
  logic [2:0]        take;
  logic [2:0]        left;
  logic              ins;
  logic [63:0]       bit_len;
  logic [63:0]       wr_en;
  logic [63:0][7:0]  wr_byte;
  logic [31:0]       wt;
  logic [31:0]       f_val;
  logic [31:0]       tmp;

  // clamp the byte count and pick the word to pack
  assign n_in     = (valid_bytes > 3'(sha1sh_pkg::WORD_BYTES)) ?
                    3'(sha1sh_pkg::WORD_BYTES) : valid_bytes;
  assign src_word = cmd.ins_pend ? pend_word : data_word;
  assign src_cnt  = cmd.ins_pend ? pend_cnt : n_in;
  assign ins      = cmd.ins_new | cmd.ins_pend;

  // split the word where it runs past the end of the block
  assign fill_sum = {1'b0, fill} + {4'b0000, src_cnt};
  assign room     = 7'(sha1sh_pkg::BLOCK_BYTES) - {1'b0, fill};
  assign take     = fill_sum[6] ? room[2:0] : src_cnt;
  assign left     = src_cnt - take;
  assign bit_len  = {msg_len, 3'b000};

  assign st.full      = fill_sum[6];
  assign st.pend_left = (left != 3'd0);
  assign st.pad_fits  = (fill < 6'(sha1sh_pkg::LEN_POS));

  // per-byte write enables and values of the block store
  always_comb begin : byte_writes
    logic [5:0] p6;
    logic [5:0] off;
    wr_en   = '0;
    wr_byte = '0;
    for (int p = 0; p < sha1sh_pkg::BLOCK_BYTES; p++) begin
      p6  = 6'(p);
      off = p6 - fill;
      if (ins && (p6 >= fill) && (off < {3'b000, take})) begin
        wr_en[p]   = 1'b1;
        wr_byte[p] = 8'(src_word >> (5'd24 - {off[1:0], 3'b000}));
      end
      if (cmd.pad) begin
        if (p6 == fill) begin
          wr_en[p]   = 1'b1;
          wr_byte[p] = sha1sh_pkg::PAD_BYTE;
        end else if (p6 > fill) begin
          wr_en[p]   = 1'b1;
          wr_byte[p] = 8'h00;
        end
        if (st.pad_fits && (p >= sha1sh_pkg::LEN_POS)) begin
          wr_en[p]   = 1'b1;
          wr_byte[p] = 8'(bit_len >> (8 * (sha1sh_pkg::BLOCK_BYTES - 1 - p)));
        end
      end
      if (cmd.len_only) begin
        wr_en[p] = 1'b1;
        if (p >= sha1sh_pkg::LEN_POS) begin
          wr_byte[p] = 8'(bit_len >> (8 * (sha1sh_pkg::BLOCK_BYTES - 1 - p)));
        end
      end
    end
  end

  // schedule word and round function
  assign wt = cmd.sched ?
              {(blk[13] ^ blk[8] ^ blk[2] ^ blk[0]) << 1} |
              {31'd0, (blk[13][31] ^ blk[8][31] ^ blk[2][31] ^ blk[0][31])} :
              blk[0];

  always_comb begin
    case (cmd.phase)
      sha1sh_pkg::PH_CH:   f_val = (wk[1] & wk[2]) | (~wk[1] & wk[3]);
      sha1sh_pkg::PH_MAJ:  f_val = (wk[1] & wk[2]) | (wk[1] & wk[3]) | (wk[2] & wk[3]);
      default:             f_val = wk[1] ^ wk[2] ^ wk[3];
    endcase
  end

  assign tmp = {wk[0][26:0], wk[0][31:27]} + f_val + wk[4] + wt +
               sha1sh_pkg::ROUND_K[cmd.phase];

  // chaining value plus working words
  always_comb begin
    for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
      digest[i] = cv[i] + wk[i];
    end
  end

  // control state: fill position, message length, chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      msg_len <= '0;
      cv      <= sha1sh_pkg::INIT_CV;
    end else begin
      if (ins) begin
        fill <= fill_sum[6] ? 6'd0 : fill_sum[5:0];
      end
      if (cmd.ins_new) begin
        msg_len <= msg_len + {58'd0, n_in};
      end
      if (cmd.fold) begin
        cv <= digest;
      end
      if (cmd.reinit) begin
        fill    <= '0;
        msg_len <= '0;
        cv      <= sha1sh_pkg::INIT_CV;
      end
    end
  end

  // payload: block store, straddle remainder, working words
  always_ff @(posedge clk) begin
    if (ins) begin
      pend_word <= src_word << {take, 3'b000};
      pend_cnt  <= left;
    end
    if (cmd.round) begin
      for (int i = 0; i < sha1sh_pkg::BLOCK_WORDS - 1; i++) begin
        blk[i] <= blk[i + 1];
      end
      blk[sha1sh_pkg::BLOCK_WORDS - 1] <= wt;
    end else begin
      for (int j = 0; j < sha1sh_pkg::BLOCK_WORDS; j++) begin
        for (int b = 0; b < sha1sh_pkg::WORD_BYTES; b++) begin
          if (wr_en[4 * j + b]) begin
            blk[j][8 * (3 - b) +: 8] <= wr_byte[4 * j + b];
          end
        end
      end
    end
    if (cmd.start) begin
      wk <= cv;
    end else if (cmd.round) begin
      wk[4] <= wk[3];
      wk[3] <= wk[2];
      wk[2] <= {wk[1][1:0], wk[1][31:2]};
      wk[1] <= wk[0];
      wk[0] <= tmp;
    end
  end

endmodule

/* hw/rtl/sha1sh_ctrl.sv */
// ----------------------------------------------------------------------------
// sha1sh_ctrl
// Controller: takes input beats, sequences insertion, padding, the 80 rounds
// and the fold, and hands the final digest to the output stage.
// ----------------------------------------------------------------------------
module sha1sh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  input  sha1sh_pkg::status_t  st,
  input  logic                 out_busy,
  output sha1sh_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD,
    S_INS,
    S_PAD,
    S_LEN
  } state_t;

  state_t     state, state_next;
  state_t     after, after_next;
  logic [6:0] rnd, rnd_next;
  logic       eom, eom_next;
  logic       fin, fin_next;

  // next state and commands
  always_comb begin
    state_next = state;
    after_next = after;
    rnd_next   = rnd;
    eom_next   = eom;
    fin_next   = fin;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ins_new = 1'b1;
          eom_next    = in_last;
          if (st.full) begin
            cmd.start  = 1'b1;
            rnd_next   = '0;
            fin_next   = 1'b0;
            state_next = S_ROUND;
            if (st.pend_left) begin
              after_next = S_INS;
            end else if (in_last) begin
              after_next = S_PAD;
            end else begin
              after_next = S_IDLE;
            end
          end else if (in_last) begin
            state_next = S_PAD;
          end
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        cmd.sched = (rnd >= 7'(sha1sh_pkg::BLOCK_WORDS));
        if (rnd < 7'(sha1sh_pkg::ROUNDS_PER_STEP)) begin
          cmd.phase = sha1sh_pkg::PH_CH;
        end else if (rnd < 7'(2 * sha1sh_pkg::ROUNDS_PER_STEP)) begin
          cmd.phase = sha1sh_pkg::PH_PAR1;
        end else if (rnd < 7'(3 * sha1sh_pkg::ROUNDS_PER_STEP)) begin
          cmd.phase = sha1sh_pkg::PH_MAJ;
        end else begin
          cmd.phase = sha1sh_pkg::PH_PAR2;
        end
        rnd_next = rnd + 7'd1;
        if (rnd == 7'(sha1sh_pkg::ROUNDS - 1)) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        if (fin) begin
          // hold until the output stage has drained the previous digest
          if (!out_busy) begin
            cmd.fold   = 1'b1;
            cmd.reinit = 1'b1;
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.fold   = 1'b1;
          state_next = after;
        end
      end
      S_INS: begin
        cmd.ins_pend = 1'b1;
        state_next   = eom ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        cmd.pad    = 1'b1;
        cmd.start  = 1'b1;
        rnd_next   = '0;
        state_next = S_ROUND;
        if (st.pad_fits) begin
          fin_next = 1'b1;
        end else begin
          fin_next   = 1'b0;
          after_next = S_LEN;
        end
      end
      S_LEN: begin
        cmd.len_only = 1'b1;
        cmd.start    = 1'b1;
        rnd_next     = '0;
        fin_next     = 1'b1;
        state_next   = S_ROUND;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      after <= S_IDLE;
      rnd   <= '0;
      eom   <= 1'b0;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      after <= after_next;
      rnd   <= rnd_next;
      eom   <= eom_next;
      fin   <= fin_next;
    end
  end

`ifndef SYNTHESIS
  a_full_starts_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && st.full) |=> (state == S_ROUND && rnd == 7'd0))
    else $error("block fill did not start compression");

  a_remainder_fits: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_pend |-> !st.full)
    else $error("straddle remainder filled a whole block");

  a_last_round_folds: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == 7'(sha1sh_pkg::ROUNDS - 1)) |=> (state == S_FOLD))
    else $error("round count overran");
`endif

endmodule

/* hw/rtl/sha1sh_out.sv */
// ----------------------------------------------------------------------------
// sha1sh_out
// Output stage: holds the five digest words and sends them one beat at a
// time, first word first, with the word position and an end marker.
// ----------------------------------------------------------------------------
module sha1sh_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [4:0][31:0]  digest,
  output logic              tvalid,
  input  logic              tready,
  output logic [31:0]       tdata,
  output logic [2:0]        tuser,
  output logic              tlast,
  output logic              busy
);

  logic [4:0][31:0] q;
  logic [2:0]       idx;

  assign tvalid = busy;
  assign tdata  = q[0];
  assign tuser  = idx;
  assign tlast  = (idx == 3'(sha1sh_pkg::DIGEST_WORDS - 1));

  // load the digest, then advance one word per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && tready) begin
      idx <= idx + 3'd1;
      if (tlast) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= digest;
    end else if (busy && tready) begin
      q <= {32'd0, q[4:1]};
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !busy)
    else $error("digest loaded while previous digest still pending");
`endif

endmodule
